[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
// Each macro checks on the rising edge of clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mbe_pkg.sv]
`default_nettype none

package mbe_pkg;

  // Default number format: signed Q8.24.
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 24;

  // Register port geometry.
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  // Field widths.
  localparam int COORD_BITS = 12;
  localparam int CNT_BITS   = 16;
  localparam int IDX_BITS   = 24;
  localparam int ESC_BITS   = 31;
  localparam int LINE_BITS  = 13;
  localparam int QUO_BITS   = 8;
  localparam int REM_BITS   = CNT_BITS + QUO_BITS;
  localparam int DSH_BITS   = CNT_BITS + QUO_BITS - 1;
  localparam int DCNT_BITS  = $clog2(QUO_BITS);

  // Register reset values.
  localparam logic [31:0]          START_RE_RST = 32'hFE00_0000;
  localparam logic [31:0]          START_IM_RST = 32'hFF00_0000;
  localparam logic [31:0]          STEP_RE_RST  = 32'h0000_C000;
  localparam logic [31:0]          STEP_IM_RST  = 32'h0000_8000;
  localparam logic [CNT_BITS-1:0]  MAX_ITER_RST = 16'd256;
  localparam logic [ESC_BITS-1:0]  ESC_RST      = 31'd1677721600;
  localparam logic [LINE_BITS-1:0] LINE_RST     = 13'd1024;

  typedef enum logic [2:0] {
    REG_START_RE   = 3'd0,
    REG_START_IM   = 3'd1,
    REG_STEP_RE    = 3'd2,
    REG_STEP_IM    = 3'd3,
    REG_MAX_ITER   = 3'd4,
    REG_ESC_RADIUS = 3'd5,
    REG_LINE_WIDTH = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRE,
    ST_CIM,
    ST_IDX,
    ST_IDXR,
    ST_TEST,
    ST_SQX,
    ST_SQY,
    ST_CRS,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/mandelbrot_escape_time_pixel_core.sv]
// Escape-time core for one Mandelbrot pixel. Raise start with a column and a row while busy is
// low and the transaction is taken on that edge; busy then stays high until the result has been
// shown. The result appears on pixel_index_o, iteration_count_o, inside_res_o and gray_o for
// exactly one cycle, marked by done_o, and must be captured then: the receiver cannot stall it.
// All multiplications run through one registered multiplier under a small sequencer. Forming
// the point c and the linear index runs through the states CRE, CIM, IDX and IDXR; each iteration
// is a test of |z|^2 in TEST followed by three multiplications in SQX, SQY and CRS. A pixel that
// escapes finishes with a restoring divider for the gray level, which a pixel that reaches the
// limit skips. The registers must be written over the APB port only while busy is low; the
// block itself does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module mandelbrot_escape_time_pixel_core #(
  parameter int WORD_BITS = mbe_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Register port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [mbe_pkg::ADDR_BITS-1:0]    paddr,
  input  wire  [mbe_pkg::DATA_BITS-1:0]    pwdata,
  output logic [mbe_pkg::DATA_BITS-1:0]    prdata,
  output logic                             pready,
  // Command side
  input  wire                              start,
  output logic                             busy,
  input  wire  [mbe_pkg::COORD_BITS-1:0]   column_i,
  input  wire  [mbe_pkg::COORD_BITS-1:0]   row_i,
  // Result side
  output logic                             done_o,
  output logic [mbe_pkg::IDX_BITS-1:0]     pixel_index_o,
  output logic [mbe_pkg::CNT_BITS-1:0]     iteration_count_o,
  output logic                             inside_res_o,
  output logic [mbe_pkg::QUO_BITS-1:0]     gray_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  // Product of a word magnitude and a 13-bit screen value.
  localparam int PW = W + 13;
  // Working width for sums before they are saturated back to a word.
  localparam int SW = ((W > 32) ? W : 32) + 15;
  localparam int MW = 2 * W;
  localparam int EW = ((W + 1) > mbe_pkg::ESC_BITS) ? (W + 1) : mbe_pkg::ESC_BITS;
  localparam logic [W-1:0] WMAX_U = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN_U = {1'b1, {(W-1){1'b0}}};

  // Clamp a wide signed value to the word range.
  function automatic logic signed [W-1:0] sat_word(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = $signed(SW'(WMAX_U));
    lo = ~hi;
    if (v > hi) begin
      sat_word = $signed(WMAX_U);
    end else if (v < lo) begin
      sat_word = $signed(WMIN_U);
    end else begin
      sat_word = v[W-1:0];
    end
  endfunction

  // Magnitude of a word; the most negative word maps to 2^(W-1), which still fits.
  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    logic [W-1:0] neg;
    neg = ~$unsigned(v) + 1'b1;
    mag = v[W-1] ? neg : $unsigned(v);
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------------
  logic [31:0]                       start_re_q, start_im_q, step_re_q, step_im_q;
  logic [mbe_pkg::CNT_BITS-1:0]      max_iter_q;
  logic [mbe_pkg::ESC_BITS-1:0]      esc_q;
  logic [mbe_pkg::LINE_BITS-1:0]     line_width_q;
  logic                              cfg_wr;
  mbe_pkg::cfg_reg_e                 cfg_sel;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = mbe_pkg::cfg_reg_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_re_q   <= mbe_pkg::START_RE_RST;
      start_im_q   <= mbe_pkg::START_IM_RST;
      step_re_q    <= mbe_pkg::STEP_RE_RST;
      step_im_q    <= mbe_pkg::STEP_IM_RST;
      max_iter_q   <= mbe_pkg::MAX_ITER_RST;
      esc_q        <= mbe_pkg::ESC_RST;
      line_width_q <= mbe_pkg::LINE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        mbe_pkg::REG_START_RE:   start_re_q   <= pwdata;
        mbe_pkg::REG_START_IM:   start_im_q   <= pwdata;
        mbe_pkg::REG_STEP_RE:    step_re_q    <= pwdata;
        mbe_pkg::REG_STEP_IM:    step_im_q    <= pwdata;
        mbe_pkg::REG_MAX_ITER:   max_iter_q   <= pwdata[mbe_pkg::CNT_BITS-1:0];
        mbe_pkg::REG_ESC_RADIUS: esc_q        <= pwdata[mbe_pkg::ESC_BITS-1:0];
        mbe_pkg::REG_LINE_WIDTH: line_width_q <= pwdata[mbe_pkg::LINE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back returns each register zero-extended; the unused slot reads as zero.
  always_comb begin
    unique case (cfg_sel)
      mbe_pkg::REG_START_RE:   prdata = start_re_q;
      mbe_pkg::REG_START_IM:   prdata = start_im_q;
      mbe_pkg::REG_STEP_RE:    prdata = step_re_q;
      mbe_pkg::REG_STEP_IM:    prdata = step_im_q;
      mbe_pkg::REG_MAX_ITER:   prdata = 32'(max_iter_q);
      mbe_pkg::REG_ESC_RADIUS: prdata = 32'(esc_q);
      mbe_pkg::REG_LINE_WIDTH: prdata = 32'(line_width_q);
      default:                 prdata = '0;
    endcase
  end

  // The 32-bit register values are clamped to the word range before use.
  logic signed [W-1:0] start_re_w, start_im_w, step_re_w, step_im_w;

  assign start_re_w = sat_word(SW'($signed(start_re_q)));
  assign start_im_w = sat_word(SW'($signed(start_im_q)));
  assign step_re_w  = sat_word(SW'($signed(step_re_q)));
  assign step_im_w  = sat_word(SW'($signed(step_im_q)));

  // ---------------------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------------------
  localparam logic [mbe_pkg::DCNT_BITS-1:0] DCNT_LAST =
    mbe_pkg::DCNT_BITS'(mbe_pkg::QUO_BITS - 1);

  mbe_pkg::state_e state_q, state_d;
  logic [mbe_pkg::DCNT_BITS-1:0] div_cnt_q;

  // Datapath registers.
  logic [mbe_pkg::COORD_BITS-1:0] col_q, row_q;
  logic [MW-1:0]                  prod_q;
  logic                           neg_q;
  logic signed [W-1:0]            cr_q, ci_q, x_q, y_q, x2_q, y2_q;
  logic [mbe_pkg::IDX_BITS-1:0]   idx_q;
  logic [mbe_pkg::CNT_BITS-1:0]   count_q;
  logic                           inside_q;
  logic [mbe_pkg::QUO_BITS-1:0]   quo_q;
  logic [mbe_pkg::REM_BITS-1:0]   rem_q;
  logic [mbe_pkg::DSH_BITS-1:0]   dsh_q;

  logic accept;
  logic lim_hit, esc_hit, stop;

  assign accept = start & ~busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbe_pkg::ST_IDLE: if (start) begin
        state_d = mbe_pkg::ST_CRE;
      end
      mbe_pkg::ST_CRE:  state_d = mbe_pkg::ST_CIM;
      mbe_pkg::ST_CIM:  state_d = mbe_pkg::ST_IDX;
      mbe_pkg::ST_IDX:  state_d = mbe_pkg::ST_IDXR;
      mbe_pkg::ST_IDXR: state_d = mbe_pkg::ST_TEST;
      mbe_pkg::ST_TEST: begin
        if (!stop) begin
          state_d = mbe_pkg::ST_SQX;
        end else if (lim_hit) begin
          state_d = mbe_pkg::ST_DONE;
        end else begin
          state_d = mbe_pkg::ST_DIV;
        end
      end
      mbe_pkg::ST_SQX:  state_d = mbe_pkg::ST_SQY;
      mbe_pkg::ST_SQY:  state_d = mbe_pkg::ST_CRS;
      mbe_pkg::ST_CRS:  state_d = mbe_pkg::ST_TEST;
      mbe_pkg::ST_DIV: if (div_cnt_q == DCNT_LAST) begin
        state_d = mbe_pkg::ST_DONE;
      end
      mbe_pkg::ST_DONE: state_d = mbe_pkg::ST_IDLE;
      default:          state_d = mbe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mbe_pkg::ST_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == mbe_pkg::ST_TEST) begin
        div_cnt_q <= '0;
      end else if (state_q == mbe_pkg::ST_DIV) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    busy   = (state_q != mbe_pkg::ST_IDLE);
    done_o = (state_q == mbe_pkg::ST_DONE);
  end

  // ---------------------------------------------------------------------------------------------
  // Shared multiplier: operands chosen by the state, product registered.
  // The product issued in one state is consumed in the state that follows it.
  // ---------------------------------------------------------------------------------------------
  logic [W-1:0]  mul_a, mul_b;
  logic          neg_d;
  logic [MW-1:0] prod_d;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    neg_d = 1'b0;
    unique case (state_q)
      mbe_pkg::ST_CRE: begin
        mul_a = mag(step_re_w);
        mul_b = W'(col_q);
        neg_d = step_re_w[W-1];
      end
      mbe_pkg::ST_CIM: begin
        mul_a = mag(step_im_w);
        mul_b = W'(row_q);
        neg_d = step_im_w[W-1];
      end
      mbe_pkg::ST_IDX: begin
        mul_a = W'(line_width_q);
        mul_b = W'(row_q);
      end
      mbe_pkg::ST_SQX: begin
        mul_a = mag(x_q);
        mul_b = mag(x_q);
      end
      mbe_pkg::ST_SQY: begin
        mul_a = mag(y_q);
        mul_b = mag(y_q);
      end
      mbe_pkg::ST_CRS: begin
        mul_a = mag(x_q);
        mul_b = mag(y_q);
        neg_d = x_q[W-1] ^ y_q[W-1];
      end
      default: ;
    endcase
  end

  assign prod_d = MW'(mul_a) * MW'(mul_b);

  // ---------------------------------------------------------------------------------------------
  // Post-processing of the registered product
  // ---------------------------------------------------------------------------------------------
  // Point c: start + position * step, exact, then clamped.
  logic signed [SW-1:0] cterm;
  logic signed [SW-1:0] cbase;
  logic signed [W-1:0]  c_new;

  always_comb begin
    cterm = $signed(SW'(prod_q[PW-1:0]));
    if (neg_q) begin
      cterm = -cterm;
    end
    cbase = (state_q == mbe_pkg::ST_CIM) ? SW'(start_re_w) : SW'(start_im_w);
    c_new = sat_word(cbase + cterm);
  end

  // Fixed-point product: the magnitude is shifted down (the cross term one place less, which
  // doubles it), clamped to the word range for its sign, then the sign is applied.
  logic          cross_term;
  logic [MW-1:0] sh, limv;
  logic [W-1:0]  rmag, rsgn;
  logic signed [W-1:0] post_val;

  always_comb begin
    cross_term = (state_q == mbe_pkg::ST_TEST);
    sh         = cross_term ? (prod_q >> (F - 1)) : (prod_q >> F);
    limv       = neg_q ? MW'(WMIN_U) : MW'(WMAX_U);
    rmag       = (sh > limv) ? limv[W-1:0] : sh[W-1:0];
    rsgn       = neg_q ? (~rmag + 1'b1) : rmag;
    post_val   = $signed(rsgn);
  end

  // Escape test and the next point of the orbit.
  logic [W:0]           sumsq;
  logic signed [W-1:0]  x_new, y_new;

  always_comb begin
    sumsq   = {1'b0, $unsigned(x2_q)} + {1'b0, $unsigned(y2_q)};
    lim_hit = (count_q >= max_iter_q);
    esc_hit = (EW'(sumsq) >= EW'(esc_q));
    stop    = lim_hit | esc_hit;
    x_new   = sat_word(SW'(cr_q) + SW'(x2_q) - SW'(y2_q));
    y_new   = sat_word(SW'(ci_q) + SW'(post_val));
  end

  // Gray level: count * 255 / limit by restoring division, one quotient bit a cycle. The pixel
  // escaped, so the count is below the limit and the quotient fits in eight bits.
  logic [mbe_pkg::REM_BITS-1:0] n_init;
  logic [mbe_pkg::DSH_BITS-1:0] dsh_init;
  logic                         ge;

  assign n_init   = {count_q, {mbe_pkg::QUO_BITS{1'b0}}} - mbe_pkg::REM_BITS'(count_q);
  assign dsh_init = {max_iter_q, {(mbe_pkg::QUO_BITS-1){1'b0}}};
  assign ge       = (rem_q >= {1'b0, dsh_q});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg_d;
    unique case (state_q)
      mbe_pkg::ST_IDLE: if (accept) begin
        col_q <= column_i;
        row_q <= row_i;
      end
      mbe_pkg::ST_CIM: cr_q <= c_new;
      mbe_pkg::ST_IDX: ci_q <= c_new;
      mbe_pkg::ST_IDXR: begin
        idx_q   <= prod_q[mbe_pkg::IDX_BITS-1:0] + mbe_pkg::IDX_BITS'(col_q);
        x2_q    <= '0;
        y2_q    <= '0;
        count_q <= '0;
      end
      mbe_pkg::ST_TEST: begin
        if (!stop) begin
          count_q <= count_q + 1'b1;
          x_q     <= x_new;
          y_q     <= y_new;
        end else begin
          inside_q <= lim_hit;
          quo_q    <= '0;
          rem_q    <= n_init;
          dsh_q    <= dsh_init;
        end
      end
      mbe_pkg::ST_SQY: x2_q <= post_val;
      mbe_pkg::ST_CRS: y2_q <= post_val;
      mbe_pkg::ST_DIV: begin
        if (ge) begin
          rem_q <= rem_q - {1'b0, dsh_q};
        end
        quo_q <= {quo_q[mbe_pkg::QUO_BITS-2:0], ge};
        dsh_q <= dsh_q >> 1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------------------------
  // Result ports, valid while done_o is high.
  // ---------------------------------------------------------------------------------------------
  assign pixel_index_o     = idx_q;
  assign iteration_count_o = count_q;
  assign inside_res_o      = inside_q;
  assign gray_o            = quo_q;

  // ---------------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------------
  `ASSERT_NEXT(a_done_one_cycle, done_o, !done_o, "result strobe held for more than one cycle")
  `ASSERT_IMPL(a_inside_black, done_o && inside_res_o, gray_o == '0,
               "inside pixel delivered with a non-zero gray level")
  `ASSERT_IMPL(a_iter_counted, state_q == mbe_pkg::ST_SQX, count_q != '0,
               "squaring started without counting the iteration")
  `ASSERT_IMPL(a_done_source, done_o,
               $past(state_q) == mbe_pkg::ST_DIV || $past(state_q) == mbe_pkg::ST_TEST,
               "result shown without passing the escape test or the divider")

endmodule

`default_nettype wire

[tb/sv/mandelbrot_pixel_checker.sv]
`timescale 1ns / 1ps

// Watches the register port, the command side and the result side of the escape-time core.
// It keeps its own copy of the registers, predicts every pixel when its transaction is taken and
// compares each result with the oldest prediction still waiting.
module mandelbrot_pixel_checker
  import mbe_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   psel_i,
  input  wire                   penable_i,
  input  wire                   pwrite_i,
  input  wire  [ADDR_BITS-1:0]  paddr_i,
  input  wire  [DATA_BITS-1:0]  pwdata_i,
  input  wire                   pready_i,
  input  wire                   start_i,
  input  wire                   busy_i,
  input  wire  [COORD_BITS-1:0] column_i,
  input  wire  [COORD_BITS-1:0] row_i,
  input  wire                   done_i,
  input  wire  [IDX_BITS-1:0]   pixel_index_i,
  input  wire  [CNT_BITS-1:0]   iteration_count_i,
  input  wire                   inside_res_i,
  input  wire  [QUO_BITS-1:0]   gray_i,
  output int                    mismatches_o,
  output int                    outstanding_o,
  output int                    results_checked_o
);

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [IDX_BITS-1:0] pixel_index;
    logic [CNT_BITS-1:0] iteration_count;
    logic                inside_flag;
    logic [QUO_BITS-1:0] gray;
  } pixel_result_t;

  logic [31:0]          cfg_start_re;
  logic [31:0]          cfg_start_im;
  logic [31:0]          cfg_step_re;
  logic [31:0]          cfg_step_im;
  logic [CNT_BITS-1:0]  cfg_max_iter;
  logic [ESC_BITS-1:0]  cfg_escape_sq;
  logic [LINE_BITS-1:0] cfg_line_width;

  pixel_result_t predicted_pixels[$];
  int            mismatch_tally;
  int            checked_tally;

  function automatic longint clamp_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // Product of two words, magnitude truncated by the shift, then clamped to the word range.
  function automatic longint scaled_product(input longint a, input longint b,
                                            input int unsigned shift);
    logic        neg;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] mag;
    logic [63:0] ceiling;
    neg   = (a < 0) != (b < 0);
    mag_a = (a < 0) ? -a : a;
    mag_b = (b < 0) ? -b : b;
    mag   = (mag_a * mag_b) >> shift;
    ceiling = neg ? 64'd2147483648 : 64'd2147483647;
    if (mag > ceiling) mag = ceiling;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic pixel_result_t escape_time_pixel(input logic [COORD_BITS-1:0] col,
                                                      input logic [COORD_BITS-1:0] row);
    pixel_result_t res;
    longint        c_re;
    longint        c_im;
    longint        x;
    longint        y;
    longint        x_sq;
    longint        y_sq;
    longint        cross_prod;
    longint        linear;
    int unsigned   count;
    int unsigned   limit;
    c_re = clamp_word(longint'($signed(cfg_start_re)) +
                      longint'(col) * longint'($signed(cfg_step_re)));
    c_im = clamp_word(longint'($signed(cfg_start_im)) +
                      longint'(row) * longint'($signed(cfg_step_im)));
    x = 0;
    y = 0;
    x_sq = 0;
    y_sq = 0;
    cross_prod = 0;
    count = 0;
    limit = cfg_max_iter;
    while (count < limit) begin
      if (x_sq + y_sq >= longint'(cfg_escape_sq)) break;
      y = clamp_word(c_im + cross_prod);
      x = clamp_word(c_re + (x_sq - y_sq));
      count++;
      x_sq       = scaled_product(x, x, FRAC_BITS_DEF);
      y_sq       = scaled_product(y, y, FRAC_BITS_DEF);
      cross_prod = scaled_product(x, y, FRAC_BITS_DEF - 1);
    end
    linear = longint'(row) * longint'(cfg_line_width) + longint'(col);
    res.pixel_index     = linear[IDX_BITS-1:0];
    res.iteration_count = count[CNT_BITS-1:0];
    res.inside_flag     = (count >= limit);
    res.gray            = res.inside_flag ? '0 : QUO_BITS'((count * 255) / limit);
    return res;
  endfunction

  function automatic int field_differs(input string name, input longint want,
                                       input longint got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_result_t oldest;
    if (!rst_ni) begin
      cfg_start_re   = START_RE_RST;
      cfg_start_im   = START_IM_RST;
      cfg_step_re    = STEP_RE_RST;
      cfg_step_im    = STEP_IM_RST;
      cfg_max_iter   = MAX_ITER_RST;
      cfg_escape_sq  = ESC_RST;
      cfg_line_width = LINE_RST;
      predicted_pixels.delete();
      mismatch_tally = 0;
      checked_tally  = 0;
    end else begin
      // A result always belongs to a pixel taken on an earlier edge, so it is checked first.
      if (done_i) begin
        if (predicted_pixels.size() == 0) begin
          $display("%0t: result (index %0d) with no pixel transaction pending",
                   $time, pixel_index_i);
          mismatch_tally++;
        end else begin
          oldest = predicted_pixels.pop_front();
          checked_tally++;
          if (field_differs("pixel_index", oldest.pixel_index, pixel_index_i) +
              field_differs("iteration_count", oldest.iteration_count, iteration_count_i) +
              field_differs("inside_res", oldest.inside_flag, inside_res_i) +
              field_differs("gray", oldest.gray, gray_i) != 0) begin
            mismatch_tally++;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (cfg_reg_e'(paddr_i[4:2]))
          REG_START_RE:   cfg_start_re   = pwdata_i;
          REG_START_IM:   cfg_start_im   = pwdata_i;
          REG_STEP_RE:    cfg_step_re    = pwdata_i;
          REG_STEP_IM:    cfg_step_im    = pwdata_i;
          REG_MAX_ITER:   cfg_max_iter   = pwdata_i[CNT_BITS-1:0];
          REG_ESC_RADIUS: cfg_escape_sq  = pwdata_i[ESC_BITS-1:0];
          REG_LINE_WIDTH: cfg_line_width = pwdata_i[LINE_BITS-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        predicted_pixels.push_back(escape_time_pixel(column_i, row_i));
      end
    end
    mismatches_o      <= mismatch_tally;
    outstanding_o     <= predicted_pixels.size();
    results_checked_o <= checked_tally;
  end

endmodule

[tb/sv/tb_mandelbrot_escape_time_pixel_core.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the escape-time pixel core. The checker beside the block does all
// the predicting and comparing; this module only programmes the registers, issues pixel
// transactions and reports the outcome.
module tb_mandelbrot_escape_time_pixel_core;
  import mbe_pkg::*;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [ADDR_BITS-1:0]  paddr   = '0;
  logic [DATA_BITS-1:0]  pwdata  = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  logic                  start   = 1'b0;
  logic                  busy;
  logic [COORD_BITS-1:0] column  = '0;
  logic [COORD_BITS-1:0] row     = '0;
  logic                  done;
  logic [IDX_BITS-1:0]   pixel_index;
  logic [CNT_BITS-1:0]   iteration_count;
  logic                  inside_res;
  logic [QUO_BITS-1:0]   gray;

  int mismatches;
  int outstanding;
  int results_checked;
  int pixels_sent = 0;
  int settings_loaded = 0;

  // The 10 ns clock.
  always #5 clk_i = ~clk_i;

  mandelbrot_escape_time_pixel_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start             (start),
    .busy              (busy),
    .column_i          (column),
    .row_i             (row),
    .done_o            (done),
    .pixel_index_o     (pixel_index),
    .iteration_count_o (iteration_count),
    .inside_res_o      (inside_res),
    .gray_o            (gray)
  );

  mandelbrot_pixel_checker u_pixel_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .pready_i          (pready),
    .start_i           (start),
    .busy_i            (busy),
    .column_i          (column),
    .row_i             (row),
    .done_i            (done),
    .pixel_index_i     (pixel_index),
    .iteration_count_i (iteration_count),
    .inside_res_i      (inside_res),
    .gray_i            (gray),
    .mismatches_o      (mismatches),
    .outstanding_o     (outstanding),
    .results_checked_o (results_checked)
  );

  // One APB write: a setup cycle, an access cycle, then a quiet cycle so that the next write
  // never touches psel in the same time step as this one releases it.
  task automatic write_register(input cfg_reg_e which, input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Every register is rewritten for each new setting, so each one is exercised many times.
  task automatic load_settings(input logic [31:0] start_re, input logic [31:0] start_im,
                               input logic [31:0] step_re, input logic [31:0] step_im,
                               input logic [CNT_BITS-1:0] max_iter,
                               input logic [ESC_BITS-1:0] escape_sq,
                               input logic [LINE_BITS-1:0] line_width);
    write_register(REG_START_RE, start_re);
    write_register(REG_START_IM, start_im);
    write_register(REG_STEP_RE, step_re);
    write_register(REG_STEP_IM, step_im);
    write_register(REG_MAX_ITER, DATA_BITS'(max_iter));
    write_register(REG_ESC_RADIUS, DATA_BITS'(escape_sq));
    write_register(REG_LINE_WIDTH, DATA_BITS'(line_width));
    settings_loaded++;
  endtask

  // Presents a pixel and holds it until the core takes it. Start is left high, so a pixel that
  // follows straight on simply replaces the coordinates; the caller lowers start for a gap.
  task automatic send_pixel(input logic [COORD_BITS-1:0] col, input logic [COORD_BITS-1:0] r);
    start  <= 1'b1;
    column <= col;
    row    <= r;
    do @(posedge clk_i); while (busy);
    pixels_sent++;
  endtask

  // Lowers start and waits for every predicted result to arrive and the core to fall idle.
  // Each pixel yields exactly one result, so nothing can still be in flight after that.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy);
  endtask

  // Coordinates are mostly uniform, with the screen edges picked now and then.
  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return COORD_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  // Random pixels in bursts of random length; gap_max of zero gives a stretch with no idling.
  task automatic random_pixels(input int count, input int gap_max);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      send_pixel(pick_coord(), pick_coord());
      burst_left--;
    end
    drain_results();
  endtask

  initial begin : stimulus
    logic [31:0]          s_re;
    logic [31:0]          s_im;
    logic [31:0]          d_re;
    logic [31:0]          d_im;
    logic [CNT_BITS-1:0]  iters;
    logic [ESC_BITS-1:0]  radius;
    logic [LINE_BITS-1:0] width;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset values: the four screen corners, a point next to the origin that never escapes and a
    // few alternating bit patterns.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd683, 12'd512);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(12'd600, 12'd600);
    drain_results();

    // A zero iteration limit: no iteration at all, the pixel counts as inside.
    load_settings(START_RE_RST, START_IM_RST, STEP_RE_RST, STEP_IM_RST, 16'd0, ESC_RST,
                  LINE_RST);
    send_pixel(12'd683, 12'd512);
    send_pixel(12'd0, 12'd0);
    drain_results();

    // A zero escape radius fails the very first test, even with the largest limit.
    load_settings(START_RE_RST, START_IM_RST, STEP_RE_RST, STEP_IM_RST, 16'hFFFF, '0,
                  LINE_RST);
    send_pixel(12'd683, 12'd512);
    send_pixel(12'd4095, 12'd4095);
    drain_results();

    // Extreme starts and steps: c clamps to the word limits, both squares and the cross term
    // saturate, and the widest line makes the linear index wrap.
    load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF,
                  '1, '1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    drain_results();

    // A limit of one with the widest radius, and a line width of zero.
    load_settings(32'hFF80_0000, 32'h0, 32'h10, 32'h10, 16'd1, '1, '0);
    send_pixel(12'd7, 12'd9);
    send_pixel(12'd4095, 12'd1);
    drain_results();

    // A window across the whole set with a short limit, so that the gray level spreads out.
    load_settings(32'hFE00_0000, 32'hFE80_0000, 32'h3000, 32'h3000, 16'd16, 31'h0400_0000,
                  13'd4096);
    send_pixel(12'd100, 12'd2048);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd3000, 12'd1000);
    send_pixel(12'd1, 12'd4094);
    drain_results();

    // Random phases, each with settings of its own. Most use short limits to keep the run
    // brief; a few use the reset limit, one a zero limit, one the largest limit with c far
    // outside so every pixel escapes at once, and one randomises every coordinate register.
    for (int phase = 0; phase < 13; phase++) begin
      s_re = 32'd0 - $urandom_range(1 << 23, 5 << 23);
      s_im = 32'd0 - $urandom_range(1 << 23, 5 << 24);
      d_re = $urandom_range(1 << 10, 1 << 14);
      d_im = $urandom_range(1 << 10, 1 << 14);
      if ($urandom_range(0, 3) == 0) d_re = 32'd0 - d_re;
      if ($urandom_range(0, 3) == 0) d_im = 32'd0 - d_im;
      iters  = CNT_BITS'($urandom_range(1, 64));
      radius = (phase % 2 == 0) ? 31'h0400_0000 : ESC_BITS'($urandom_range(0, 32'h7FFF_FFFF));
      width  = LINE_BITS'($urandom_range(0, 8191));
      case (phase)
        3: begin
          s_re  = 32'h4000_0000 + $urandom_range(0, 1 << 28);
          d_re  = $urandom_range(0, 1 << 16);
          iters = 16'hFFFF;
        end
        5: iters = '0;
        7, 11: iters = 16'd256;
        9: begin
          s_re = $urandom;
          s_im = $urandom;
          d_re = $urandom;
          d_im = $urandom;
        end
        default: ;
      endcase
      load_settings(s_re, s_im, d_re, d_im, iters, radius, width);
      random_pixels(60, (phase % 3 == 1) ? 0 : $urandom_range(4, 40));
    end

    // Let the core settle for a while after the final result before giving the verdict.
    repeat (64) @(posedge clk_i);
    $display("Covered %0d pixel transactions under %0d register settings; %0d results compared.",
             pixels_sent, settings_loaded + 1, results_checked);
    if (mismatches == 0) begin
      $display("mandelbrot_escape_time_pixel_core regression: pass");
    end else begin
      $display("mandelbrot_escape_time_pixel_core regression: fail");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run.
  initial begin : watchdog
    #15_000_000;
    $display("Timed out with %0d results still awaited.", outstanding);
    $display("mandelbrot_escape_time_pixel_core regression: fail");
    $finish;
  end

endmodule
